### rtl/pdrc_pkg.sv
// Shared types and constants of the power domain reference count controller.
// No dependencies; every other file of the block but pdrc_ram refers to this package.
package pdrc_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // status codes of a result beat
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_INVALID_ARG   = 2'd1;
  localparam logic [1:0] ST_INVALID_STATE = 2'd2;

  // configuration register map
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROLLER_READY = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_DELAY_TICKS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS_D0  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS_D1  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS_D2  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS_D3  = 3'd5;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] OFF_DELAY_RESET  = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] SETTLE_D0_RESET  = 16'd100;
  localparam logic [CFG_DATA_W-1:0] SETTLE_D1_RESET  = 16'd100;
  localparam logic [CFG_DATA_W-1:0] SETTLE_D2_RESET  = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] SETTLE_D3_RESET  = 16'd2000;

  // settle registers and domains visible on drive and settled
  localparam int unsigned SETTLE_REGS = 4;
  localparam int unsigned SHOWN_W     = 4;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] domain;
    logic [7:0] consumer;
    logic       shutdown;
  } pdrc_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SHOWN_W-1:0] drive;
    logic [SHOWN_W-1:0] settled;
    logic [7:0]         user_count;
    logic               table_full;
    logic               not_found;
    logic               count_saturated;
  } pdrc_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } pdrc_cmd_t;

endpackage

### rtl/power_domain_refcount_controller.sv
// Reference counted power domain controller. Each input beat is a request, a release or a
// one millisecond tick; each produces exactly one result beat. An item is handled in order:
// first the addressed domain's consumer row is read from the slot RAM, then all slots are
// compared in parallel, counts and timers are updated and the result register is loaded.
// The next beat is accepted in the cycle after that, while the result may still wait to be
// taken; a result not yet taken holds the following item in its update step. Consumer slot
// occupancy lives in flip-flops cleared by reset, so no clearing pass is needed.
// Uses pdrc_pkg, pdrc_ctrl, pdrc_datapath and pdrc_ram.
module power_domain_refcount_controller #(
  parameter int unsigned SLOTS_PER_DOMAIN = 8,
  parameter int unsigned DOMAINS          = 4,
  parameter int unsigned ID_BITS          = 8,
  parameter int unsigned TIMER_BITS       = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pdrc_pkg::pdrc_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pdrc_pkg::pdrc_out_t              out_data,
  input  logic                             cfg_write,
  input  logic [pdrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pdrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pdrc_pkg::pdrc_cmd_t cmd;

  // sequencing
  pdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // tables, counters and timers
  pdrc_datapath #(
    .SLOTS_PER_DOMAIN (SLOTS_PER_DOMAIN),
    .DOMAINS          (DOMAINS),
    .ID_BITS          (ID_BITS),
    .TIMER_BITS       (TIMER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // an accepted beat keeps the input side closed for its update cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("input accepted again before update");

  // flags are only raised on a successful access
  a_flags_need_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != pdrc_pkg::ST_OK) |->
      !out_data.table_full && !out_data.not_found && !out_data.count_saturated)
    else $error("flag raised on a refused access");

  // a domain can only be settled while driven
  a_settled_driven: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.settled & ~out_data.drive) == '0))
    else $error("settled without drive");

  // update fires only when the result register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

### rtl/pdrc_ram.sv
// Generic single write port RAM with registered read and read enable.
// No dependencies.
module pdrc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pdrc_ctrl.sv
// Sequencing state machine: accepts a beat, waits for the slot row read,
// then fires the update once the result register is free. Uses pdrc_pkg.
module pdrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pdrc_pkg::pdrc_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   res_free;

  // result register may be loaded when empty or being drained
  assign res_free    = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE) && !rst;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state == S_EXEC) && res_free;

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/pdrc_datapath.sv
// Datapath: configuration registers, consumer slot table, counts, timers
// and the result register. Uses pdrc_pkg and pdrc_ram.
module pdrc_datapath #(
  parameter int unsigned SLOTS_PER_DOMAIN = 8,
  parameter int unsigned DOMAINS          = 4,
  parameter int unsigned ID_BITS          = 8,
  parameter int unsigned TIMER_BITS       = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pdrc_pkg::pdrc_cmd_t                 cmd,
  input  pdrc_pkg::pdrc_in_t                  in_data,
  input  logic                                cfg_write,
  input  logic [pdrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pdrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pdrc_pkg::pdrc_out_t                 out_data
);

  localparam int unsigned SLOTS  = SLOTS_PER_DOMAIN;
  localparam int unsigned DIDX_W = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  localparam int unsigned ROW_W  = SLOTS * ID_BITS;
  localparam int unsigned CMP_W  = (TIMER_BITS > pdrc_pkg::CFG_DATA_W) ?
                                   TIMER_BITS : pdrc_pkg::CFG_DATA_W;
  localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((64'd1 << TIMER_BITS) - 64'd1);
  localparam int unsigned SHOWN  = (DOMAINS < pdrc_pkg::SHOWN_W) ?
                                   DOMAINS : pdrc_pkg::SHOWN_W;

  // saturate a register value into a timer
  function automatic logic [TIMER_BITS-1:0] load_timer(
    input logic [pdrc_pkg::CFG_DATA_W-1:0] v
  );
    logic [CMP_W-1:0] ve;
    begin
      ve = CMP_W'(v);
      if (ve > TIMER_MAX) begin
        load_timer = TIMER_BITS'(TIMER_MAX);
      end else begin
        load_timer = TIMER_BITS'(ve);
      end
    end
  endfunction

  // configuration registers
  logic                                controller_ready;
  logic [pdrc_pkg::CFG_DATA_W-1:0]     off_delay_ticks;
  logic [pdrc_pkg::CFG_DATA_W-1:0]     settle_ticks [pdrc_pkg::SETTLE_REGS];

  // captured beat
  pdrc_pkg::pdrc_in_t item;

  // per domain state
  logic [SLOTS-1:0]      slot_used      [DOMAINS];
  logic [7:0]            ref_total      [DOMAINS];
  logic [DOMAINS-1:0]    domain_on;
  logic [TIMER_BITS-1:0] settle_timer   [DOMAINS];
  logic [DOMAINS-1:0]    off_pending;
  logic [TIMER_BITS-1:0] off_timer      [DOMAINS];

  logic [SLOTS-1:0]      slot_used_next [DOMAINS];
  logic [7:0]            ref_total_next [DOMAINS];
  logic [DOMAINS-1:0]    domain_on_next;
  logic [TIMER_BITS-1:0] settle_timer_next [DOMAINS];
  logic [DOMAINS-1:0]    off_pending_next;
  logic [TIMER_BITS-1:0] off_timer_next [DOMAINS];
  pdrc_pkg::pdrc_out_t   out_next;

  // slot row and lookup
  logic [SLOTS-1:0][ID_BITS-1:0] owner_row;
  logic [SLOTS-1:0][ID_BITS-1:0] wr_row;
  logic [ROW_W-1:0]              rd_bits;
  logic [DIDX_W-1:0]             didx;
  logic [DIDX_W-1:0]             in_didx;
  logic [ID_BITS-1:0]            who;
  logic [SLOTS-1:0]              used_row;
  logic [SLOTS-1:0]              match;
  logic [SLOTS-1:0]              cand;
  logic [SLOTS-1:0]              hit;
  logic [SLOTS-1:0]              req_sel;
  logic [SLOTS-1:0]              rel_sel;
  logic                          tracked;
  logic                          in_range;
  logic                          is_access;
  logic                          do_req;
  logic                          do_rel;
  logic [7:0]                    cnt_dec;
  logic [TIMER_BITS-1:0]         off_load;
  logic [TIMER_BITS-1:0]         settle_load;

  assign didx     = DIDX_W'(item.domain);
  assign in_didx  = DIDX_W'(in_data.domain);
  assign who      = ID_BITS'(item.consumer);
  assign in_range = ({2'b00, item.domain} < 4'(DOMAINS));

  // consumer rows, one per domain
  pdrc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DOMAINS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.execute && do_req),
    .waddr (didx),
    .wdata (wr_row),
    .re    (cmd.capture),
    .raddr (in_didx),
    .rdata (rd_bits)
  );

  assign owner_row = rd_bits;

  // slot compare and first-slot selection
  always_comb begin
    used_row = slot_used[didx];
    for (int s = 0; s < SLOTS; s++) begin
      match[s]  = (owner_row[s] == who);
      wr_row[s] = owner_row[s];
    end
    cand    = ~used_row | match;
    hit     = used_row & match;
    tracked = |hit;
    req_sel = cand & (~cand + SLOTS'(1));
    rel_sel = hit & (~hit + SLOTS'(1));
    for (int s = 0; s < SLOTS; s++) begin
      if (req_sel[s]) begin
        wr_row[s] = who;
      end
    end
  end

  assign is_access   = (item.operation == pdrc_pkg::OP_REQUEST) ||
                       (item.operation == pdrc_pkg::OP_RELEASE);
  assign do_req      = (item.operation == pdrc_pkg::OP_REQUEST) && controller_ready &&
                       in_range && !item.shutdown;
  assign do_rel      = (item.operation == pdrc_pkg::OP_RELEASE) && controller_ready &&
                       in_range;
  assign cnt_dec     = (ref_total[didx] != 8'd0) ? (ref_total[didx] - 8'd1) : 8'd0;
  assign off_load    = load_timer(off_delay_ticks);
  assign settle_load = load_timer(settle_ticks[item.domain]);

  // next state and result of the captured beat
  always_comb begin
    slot_used_next    = slot_used;
    ref_total_next    = ref_total;
    domain_on_next    = domain_on;
    settle_timer_next = settle_timer;
    off_pending_next  = off_pending;
    off_timer_next    = off_timer;
    out_next          = '0;

    if (is_access && (!controller_ready || !in_range)) begin
      out_next.status = pdrc_pkg::ST_INVALID_ARG;
    end else if ((item.operation == pdrc_pkg::OP_REQUEST) && item.shutdown) begin
      out_next.status = pdrc_pkg::ST_INVALID_STATE;
    end else begin
      out_next.status = pdrc_pkg::ST_OK;
    end

    case (item.operation)
      pdrc_pkg::OP_REQUEST: begin
        if (do_req) begin
          slot_used_next[didx] = used_row | req_sel;
          out_next.table_full  = ~|cand;
          if (!tracked) begin
            if (ref_total[didx] == pdrc_pkg::COUNT_MAX) begin
              out_next.count_saturated = 1'b1;
            end else begin
              ref_total_next[didx] = ref_total[didx] + 8'd1;
            end
          end
          if (!domain_on[didx]) begin
            domain_on_next[didx]    = 1'b1;
            settle_timer_next[didx] = settle_load;
          end
        end
      end
      pdrc_pkg::OP_RELEASE: begin
        if (do_rel) begin
          slot_used_next[didx] = used_row & ~rel_sel;
          out_next.not_found   = ~|hit;
          ref_total_next[didx] = cnt_dec;
          if ((cnt_dec == 8'd0) && domain_on[didx]) begin
            if (off_load == '0) begin
              domain_on_next[didx]    = 1'b0;
              off_pending_next[didx]  = 1'b0;
              off_timer_next[didx]    = '0;
              settle_timer_next[didx] = '0;
            end else begin
              off_pending_next[didx] = 1'b1;
              off_timer_next[didx]   = off_load;
            end
          end
        end
      end
      pdrc_pkg::OP_TICK: begin
        for (int d = 0; d < DOMAINS; d++) begin
          if (settle_timer[d] != '0) begin
            settle_timer_next[d] = settle_timer[d] - TIMER_BITS'(1);
          end
          if (off_pending[d]) begin
            if (off_timer[d] != '0) begin
              off_timer_next[d] = off_timer[d] - TIMER_BITS'(1);
            end
            // expiry: switch off only if still unused
            if (off_timer[d] < TIMER_BITS'(2)) begin
              off_pending_next[d] = 1'b0;
              if ((ref_total[d] == 8'd0) && domain_on[d]) begin
                domain_on_next[d]    = 1'b0;
                off_timer_next[d]    = '0;
                settle_timer_next[d] = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase

    // outputs after the update
    for (int i = 0; i < SHOWN; i++) begin
      out_next.drive[i]   = domain_on_next[i] && !item.shutdown;
      out_next.settled[i] = domain_on_next[i] && !item.shutdown &&
                            (settle_timer_next[i] == '0);
    end
    out_next.user_count = in_range ? ref_total_next[didx] : 8'd0;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      controller_ready <= 1'b0;
      off_delay_ticks  <= pdrc_pkg::OFF_DELAY_RESET;
      settle_ticks[0]  <= pdrc_pkg::SETTLE_D0_RESET;
      settle_ticks[1]  <= pdrc_pkg::SETTLE_D1_RESET;
      settle_ticks[2]  <= pdrc_pkg::SETTLE_D2_RESET;
      settle_ticks[3]  <= pdrc_pkg::SETTLE_D3_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pdrc_pkg::REG_CONTROLLER_READY: controller_ready <= cfg_data[0];
        pdrc_pkg::REG_OFF_DELAY_TICKS:  off_delay_ticks  <= cfg_data;
        pdrc_pkg::REG_SETTLE_TICKS_D0:  settle_ticks[0]  <= cfg_data;
        pdrc_pkg::REG_SETTLE_TICKS_D1:  settle_ticks[1]  <= cfg_data;
        pdrc_pkg::REG_SETTLE_TICKS_D2:  settle_ticks[2]  <= cfg_data;
        pdrc_pkg::REG_SETTLE_TICKS_D3:  settle_ticks[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured beat and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.execute) begin
      out_data <= out_next;
    end
  end

  // domain state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DOMAINS; d++) begin
        slot_used[d]    <= '0;
        ref_total[d]    <= '0;
        settle_timer[d] <= '0;
        off_timer[d]    <= '0;
      end
      domain_on   <= '0;
      off_pending <= '0;
    end else if (cmd.execute) begin
      slot_used    <= slot_used_next;
      ref_total    <= ref_total_next;
      domain_on    <= domain_on_next;
      settle_timer <= settle_timer_next;
      off_pending  <= off_pending_next;
      off_timer    <= off_timer_next;
    end
  end

endmodule
